>>> hw/rtl/mi3_pkg.sv
package mi3_pkg;

	localparam int ENTRY_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int N_ENT           = 9;
	localparam int N_COL           = 3;

	typedef struct packed {
		logic vld;
		logic det_neg;
		logic det_zero;
	} mi3_ctl_t;

endpackage

>>> hw/rtl/mi3_cofactor.sv
module mi3_cofactor import mi3_pkg::*; #(
	parameter int W = ENTRY_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  logic signed [W-1:0]   a [N_ENT],
	output logic                  out_vld,
	output logic signed [2*W:0]   cof [N_ENT],
	output logic signed [W-1:0]   row0 [N_COL]
);

	logic signed [2*W-1:0] p1_s1 [N_ENT];
	logic signed [2*W-1:0] p2_s1 [N_ENT];
	logic signed [W-1:0]   row0_s1 [N_COL];
	logic signed [W-1:0]   row0_s2 [N_COL];
	logic signed [2*W:0]   cof_s2 [N_ENT];
	logic                  vld_s1, vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			localparam int R1 = (r + 1) % 3;
			localparam int R2 = (r + 2) % 3;
			localparam int C1 = (c + 1) % 3;
			localparam int C2 = (c + 2) % 3;
			localparam int K  = r * 3 + c;
			always_ff @(posedge clk) begin
				p1_s1[K]  <= a[R1*3+C1] * a[R2*3+C2];
				p2_s1[K]  <= a[R1*3+C2] * a[R2*3+C1];
				cof_s2[K] <= (2*W+1)'(p1_s1[K]) - (2*W+1)'(p2_s1[K]);
			end
		end
	end

	always_ff @(posedge clk) begin
		row0_s1 <= a[0:N_COL-1];
		row0_s2 <= row0_s1;
	end

	assign out_vld = vld_s2;
	assign cof     = cof_s2;
	assign row0    = row0_s2;

endmodule

>>> hw/rtl/mi3_det.sv
module mi3_det import mi3_pkg::*; #(
	parameter int W = ENTRY_WIDTH_DEF,
	localparam int DW = 3 * W + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  logic signed [2*W:0]   cof [N_ENT],
	input  logic signed [W-1:0]   row0 [N_COL],
	output mi3_ctl_t              ctl,
	output logic [DW-1:0]         den,
	output logic [2*W-1:0]        num [N_ENT],
	output logic                  num_neg [N_ENT]
);

	logic signed [2*W:0] lo_s3 [N_COL];
	logic signed [2*W:0] hi_s3 [N_COL];
	logic signed [DW-1:0] col_s4 [N_COL];
	logic signed [DW-1:0] det_s5;
	logic signed [2*W:0] cof_s3 [N_ENT];
	logic signed [2*W:0] cof_s4 [N_ENT];
	logic signed [2*W:0] cof_s5 [N_ENT];
	logic [DW-1:0]       den_s6;
	logic [2*W-1:0]      num_s6 [N_ENT];
	logic                neg_s6 [N_ENT];
	logic                vld_s3, vld_s4, vld_s5;
	mi3_ctl_t            ctl_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			ctl_s6 <= '0;
		end else begin
			vld_s3          <= in_vld;
			vld_s4          <= vld_s3;
			vld_s5          <= vld_s4;
			ctl_s6.vld      <= vld_s5;
			ctl_s6.det_neg  <= det_s5[DW-1];
			ctl_s6.det_zero <= (det_s5 == '0);
		end
	end

	// cofactor split into low unsigned and high signed halves
	for (genvar c = 0; c < N_COL; c++) begin : g_col
		always_ff @(posedge clk) begin
			lo_s3[c]  <= row0[c] * $signed({1'b0, cof[c][W-1:0]});
			hi_s3[c]  <= row0[c] * $signed(cof[c][2*W:W]);
			col_s4[c] <= (DW'(hi_s3[c]) <<< W) + DW'(lo_s3[c]);
		end
	end

	for (genvar k = 0; k < N_ENT; k++) begin : g_ent
		always_ff @(posedge clk) begin
			cof_s3[k] <= cof[k];
			cof_s4[k] <= cof_s3[k];
			cof_s5[k] <= cof_s4[k];
			neg_s6[k] <= cof_s5[k][2*W];
			num_s6[k] <= cof_s5[k][2*W] ? (2*W)'(-cof_s5[k]) : (2*W)'(cof_s5[k]);
		end
	end

	always_ff @(posedge clk) begin
		det_s5 <= col_s4[0] + col_s4[1] + col_s4[2];
		den_s6 <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
	end

	assign ctl     = ctl_s6;
	assign den     = den_s6;
	assign num     = num_s6;
	assign num_neg = neg_s6;

endmodule

>>> hw/rtl/mi3_divider.sv
module mi3_divider import mi3_pkg::*; #(
	parameter int W = ENTRY_WIDTH_DEF,
	parameter int F = FRAC_BITS_DEF,
	localparam int DW = 3 * W + 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mi3_ctl_t         ctl,
	input  logic [DW-1:0]    den,
	input  logic [2*W-1:0]   num [N_ENT],
	input  logic             num_neg [N_ENT],
	output logic             out_vld,
	output logic [W-1:0]     q [N_ENT],
	output logic             singular,
	output logic             overflowed
);

	localparam int NW = 2 * W + 2 * F;
	localparam int QB = W + 1;
	localparam int RW = ((NW > DW) ? NW : DW) + 1;

	logic [RW-1:0] rem_s [QB+1][N_ENT];
	logic [QB-1:0] nlo_s [QB+1][N_ENT];
	logic [QB-1:0] qb_s  [QB+1][N_ENT];
	logic          big_s [QB+1][N_ENT];
	logic          neg_s [QB+1][N_ENT];
	logic [DW-1:0] den_s [QB+1];
	logic          vld_s [QB+1];
	logic          zero_s [QB+1];

	logic [QB:0]   qr_sr [N_ENT];
	logic          big_sr [N_ENT];
	logic          neg_sr [N_ENT];
	logic          vld_sr, zero_sr;

	logic [W-1:0]  q_q [N_ENT];
	logic          sat [N_ENT];
	logic [W-1:0]  val [N_ENT];
	logic          vld_q, sing_q, ovf_q;
	logic          any_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= QB; j++) vld_s[j] <= 1'b0;
			vld_sr <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			vld_s[0] <= ctl.vld;
			for (int j = 1; j <= QB; j++) vld_s[j] <= vld_s[j-1];
			vld_sr <= vld_s[QB];
			vld_q  <= vld_sr;
		end
	end

	always_ff @(posedge clk) begin
		den_s[0]  <= den;
		zero_s[0] <= ctl.det_zero;
		for (int j = 1; j <= QB; j++) begin
			den_s[j]  <= den_s[j-1];
			zero_s[j] <= zero_s[j-1];
		end
		zero_sr <= zero_s[QB];
	end

	for (genvar l = 0; l < N_ENT; l++) begin : g_lane
		logic [NW-1:0] nfull;
		logic [RW-1:0] rem0;
		logic          rup;
		logic [QB:0]   lim;

		assign nfull = {num[l], (2*F)'(0)};
		assign rem0  = RW'(nfull >> QB);

		always_ff @(posedge clk) begin
			rem_s[0][l] <= rem0;
			nlo_s[0][l] <= nfull[QB-1:0];
			qb_s[0][l]  <= '0;
			big_s[0][l] <= (rem0 >= RW'(den));
			neg_s[0][l] <= num_neg[l] ^ ctl.det_neg;
		end

		for (genvar j = 1; j <= QB; j++) begin : g_step
			logic [RW-1:0] t;
			logic          ge;
			assign t  = {rem_s[j-1][l][RW-2:0], nlo_s[j-1][l][QB-1]};
			assign ge = (t >= RW'(den_s[j-1]));
			always_ff @(posedge clk) begin
				rem_s[j][l] <= ge ? t - RW'(den_s[j-1]) : t;
				nlo_s[j][l] <= nlo_s[j-1][l] << 1;
				qb_s[j][l]  <= {qb_s[j-1][l][QB-2:0], ge};
				big_s[j][l] <= big_s[j-1][l];
				neg_s[j][l] <= neg_s[j-1][l];
			end
		end

		// round to nearest, ties away from zero
		assign rup = ({rem_s[QB][l], 1'b0} >= (RW+1)'(den_s[QB]));

		always_ff @(posedge clk) begin
			qr_sr[l]  <= (QB+1)'(qb_s[QB][l]) + (QB+1)'(rup);
			big_sr[l] <= big_s[QB][l];
			neg_sr[l] <= neg_s[QB][l];
		end

		assign lim    = neg_sr[l] ? (QB+1)'(1) << (W-1) : ((QB+1)'(1) << (W-1)) - 1'b1;
		assign sat[l] = big_sr[l] || (qr_sr[l] > lim);
		assign val[l] = sat[l] ? (neg_sr[l] ? W'(-lim) : W'(lim))
		                       : (neg_sr[l] ? W'(-qr_sr[l]) : W'(qr_sr[l]));

		always_ff @(posedge clk) begin
			q_q[l] <= zero_sr ? '0 : val[l];
		end
	end

	always_comb begin
		any_sat = 1'b0;
		for (int l = 0; l < N_ENT; l++) any_sat = any_sat | sat[l];
	end

	always_ff @(posedge clk) begin
		sing_q <= zero_sr;
		ovf_q  <= any_sat && !zero_sr;
	end

	assign out_vld    = vld_q;
	assign q          = q_q;
	assign singular   = sing_q;
	assign overflowed = ovf_q;

endmodule

>>> hw/rtl/matrix3x3_inverse_unit.sv
// start passes through the cofactor, determinant and divider pipelines to done
// throughput: one matrix per cycle, set by the one-bit-per-stage divider lanes
// busy is always low; the receiver cannot stall, results leave on the done strobe
// reset clears the valid bits along the pipeline, in-flight transactions are dropped
module matrix3x3_inverse_unit import mi3_pkg::*; #(
	parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [ENTRY_WIDTH-1:0] a00, a01, a02,
	input  logic signed [ENTRY_WIDTH-1:0] a10, a11, a12,
	input  logic signed [ENTRY_WIDTH-1:0] a20, a21, a22,
	output logic                          done,
	output logic signed [ENTRY_WIDTH-1:0] b00, b01, b02,
	output logic signed [ENTRY_WIDTH-1:0] b10, b11, b12,
	output logic signed [ENTRY_WIDTH-1:0] b20, b21, b22,
	output logic                          singular,
	output logic                          overflowed
);

	localparam int W  = ENTRY_WIDTH;
	localparam int DW = 3 * W + 2;

	logic signed [W-1:0]   a [N_ENT];
	logic                  cof_vld;
	logic signed [2*W:0]   cof [N_ENT];
	logic signed [W-1:0]   row0 [N_COL];
	mi3_ctl_t              ctl;
	logic [DW-1:0]         den;
	logic [2*W-1:0]        num [N_ENT];
	logic                  num_neg [N_ENT];
	logic [W-1:0]          q [N_ENT];

	assign busy = 1'b0;

	assign a = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

	mi3_cofactor #(.W(W)) u_cof (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.a       (a),
		.out_vld (cof_vld),
		.cof     (cof),
		.row0    (row0)
	);

	mi3_det #(.W(W)) u_det (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (cof_vld),
		.cof     (cof),
		.row0    (row0),
		.ctl     (ctl),
		.den     (den),
		.num     (num),
		.num_neg (num_neg)
	);

	mi3_divider #(.W(W), .F(FRAC_BITS)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.den        (den),
		.num        (num),
		.num_neg    (num_neg),
		.out_vld    (done),
		.q          (q),
		.singular   (singular),
		.overflowed (overflowed)
	);

	// inverse is the transposed cofactor matrix divided by the determinant
	assign b00 = q[0];
	assign b01 = q[3];
	assign b02 = q[6];
	assign b10 = q[1];
	assign b11 = q[4];
	assign b12 = q[7];
	assign b20 = q[2];
	assign b21 = q[5];
	assign b22 = q[8];

	a_sing_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		done && singular |-> !overflowed)
		else $error("overflow flagged on singular matrix");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && singular |-> (b00 == '0) && (b01 == '0) && (b02 == '0) && (b10 == '0) &&
			(b11 == '0) && (b12 == '0) && (b20 == '0) && (b21 == '0) && (b22 == '0))
		else $error("nonzero entry on singular matrix");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !busy)
		else $error("pipeline refused a transaction");

endmodule
